// ----- hw/rtl/air_sensor_frame_parser_assert.svh -----
// Assertion macros for the checker file.
`ifndef AIR_SENSOR_FRAME_PARSER_ASSERT_SVH
`define AIR_SENSOR_FRAME_PARSER_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define ASFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/asfp_pkg.sv -----
`timescale 1ns / 1ps

package asfp_pkg;

   // Header bytes and checksum seed
   localparam logic [7:0] HDR_FIRST  = 8'hFF;
   localparam logic [7:0] HDR_SECOND = 8'h18;

   // Frame positions of the next byte
   localparam logic [2:0] POS_IDLE   = 3'd0;
   localparam logic [2:0] POS_FIRST  = 3'd1;
   localparam logic [2:0] POS_PM_HI  = 3'd2;
   localparam logic [2:0] POS_PM_LO  = 3'd3;
   localparam logic [2:0] POS_TVOC   = 3'd6;
   localparam logic [2:0] POS_CHECK  = 3'd7;

   // PM2.5 level codes
   localparam logic [2:0] PM_LVL_NONE     = 3'd0;
   localparam logic [2:0] PM_LVL_BEST     = 3'd1;
   localparam logic [2:0] PM_LVL_GOOD     = 3'd2;
   localparam logic [2:0] PM_LVL_MODERATE = 3'd3;
   localparam logic [2:0] PM_LVL_BAD      = 3'd4;

   // TVOC level codes
   localparam logic [2:0] TVOC_LVL_BEST     = 3'd0;
   localparam logic [2:0] TVOC_LVL_GOOD     = 3'd1;
   localparam logic [2:0] TVOC_LVL_MODERATE = 3'd2;
   localparam logic [2:0] TVOC_LVL_BAD      = 3'd3;
   localparam logic [2:0] TVOC_LVL_NONE     = 3'd4;

   // One result item
   typedef struct packed {
      logic [15:0] pm25_value;
      logic [7:0]  tvoc_value;
      logic [2:0]  pm25_level;
      logic [2:0]  tvoc_level;
      logic        checksum_ok;
   } result_type;

   // Level from the PM2.5 high byte
   function automatic logic [2:0] pm25_level_of(input logic [7:0] hi);
      logic [2:0] lvl;
      if (hi == 8'd0) begin
         lvl = PM_LVL_NONE;
      end else if (hi <= 8'd2) begin
         lvl = PM_LVL_BEST;
      end else if (hi <= 8'd4) begin
         lvl = PM_LVL_GOOD;
      end else if (hi <= 8'd6) begin
         lvl = PM_LVL_MODERATE;
      end else begin
         lvl = PM_LVL_BAD;
      end
      return lvl;
   endfunction

   // Level from the raw TVOC byte
   function automatic logic [2:0] tvoc_level_of(input logic [7:0] v);
      logic [2:0] lvl;
      case (v)
         8'd0:    lvl = TVOC_LVL_BEST;
         8'd1:    lvl = TVOC_LVL_GOOD;
         8'd2:    lvl = TVOC_LVL_MODERATE;
         8'd3:    lvl = TVOC_LVL_BAD;
         default: lvl = TVOC_LVL_NONE;
      endcase
      return lvl;
   endfunction

endpackage

// ----- hw/rtl/asfp_parser.sv -----
`timescale 1ns / 1ps

module asfp_parser import asfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       result_valid,
   output result_type result
);

   logic       in_frame_ff, in_frame_in;
   logic [2:0] frame_pos_ff, frame_pos_in;
   logic [7:0] prev_byte_ff, prev_byte_in;
   logic [7:0] run_sum_ff, run_sum_in;
   logic [7:0] pm_hi_ff, pm_lo_ff, tvoc_ff;
   logic       is_data;
   logic [7:0] expect_sum;

   assign is_data    = (frame_pos_ff != POS_IDLE) && (frame_pos_ff != POS_CHECK);
   assign expect_sum = 8'(8'd0 - run_sum_ff);

   // Next state of the frame tracker
   always_comb begin
      in_frame_in  = in_frame_ff;
      frame_pos_in = frame_pos_ff;
      prev_byte_in = prev_byte_ff;
      run_sum_in   = run_sum_ff;
      result_valid = 1'b0;
      if (byte_valid) begin
         if (!in_frame_ff) begin
            if (byte_data == HDR_SECOND) begin
               // lone 0x18 leaves the previous byte alone
               if (prev_byte_ff == HDR_FIRST) begin
                  in_frame_in  = 1'b1;
                  frame_pos_in = POS_FIRST;
                  run_sum_in   = HDR_SECOND;
               end
            end else begin
               prev_byte_in = byte_data;
            end
         end else begin
            prev_byte_in = byte_data;
            if (is_data) begin
               run_sum_in   = 8'(run_sum_ff + byte_data);
               frame_pos_in = 3'(frame_pos_ff + 3'd1);
            end else begin
               // checksum byte: emit and close the frame
               result_valid = 1'b1;
               in_frame_in  = 1'b0;
               frame_pos_in = POS_IDLE;
               run_sum_in   = HDR_SECOND;
            end
         end
      end
   end

   // Result fields from the captured bytes
   always_comb begin
      result.pm25_value  = {pm_hi_ff, pm_lo_ff};
      result.tvoc_value  = tvoc_ff;
      result.pm25_level  = pm25_level_of(pm_hi_ff);
      result.tvoc_level  = tvoc_level_of(tvoc_ff);
      result.checksum_ok = (byte_data == expect_sum);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         frame_pos_ff <= POS_IDLE;
         prev_byte_ff <= 8'd0;
         run_sum_ff   <= HDR_SECOND;
      end else begin
         in_frame_ff  <= in_frame_in;
         frame_pos_ff <= frame_pos_in;
         prev_byte_ff <= prev_byte_in;
         run_sum_ff   <= run_sum_in;
      end
   end

   // Captured data bytes, only the ones a result needs
   always_ff @(posedge clock) begin
      if (byte_valid && in_frame_ff) begin
         if (frame_pos_ff == POS_PM_HI) pm_hi_ff <= byte_data;
         if (frame_pos_ff == POS_PM_LO) pm_lo_ff <= byte_data;
         if (frame_pos_ff == POS_TVOC)  tvoc_ff  <= byte_data;
      end
   end

endmodule

// ----- hw/rtl/asfp_out_stage.sv -----
`timescale 1ns / 1ps

module asfp_out_stage import asfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       free,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Room for a new result when empty or being drained this cycle
   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ----- hw/rtl/air_sensor_frame_parser.sv -----
// A frame's result is registered and shown in the cycle after its checksum byte transfer.
// Throughput: one byte per cycle; the single output register gates req_ready
// only while a result waits and rsp_ready is low.
// Reset: synchronous, active high; clears the frame tracker and empties the
// output register. No clearing pass.
`timescale 1ns / 1ps

module air_sensor_frame_parser import asfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pm25_value,
   output logic [7:0]  rsp_tvoc_value,
   output logic [2:0]  rsp_pm25_level,
   output logic [2:0]  rsp_tvoc_level,
   output logic        rsp_checksum_ok
);

   logic       req_xfer;
   logic       res_valid;
   logic       out_free;
   result_type res_data;
   result_type out_data;

   assign req_ready = out_free;
   assign req_xfer  = req_valid && out_free;

   asfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_xfer),
      .byte_data    (req_rx_byte),
      .result_valid (res_valid),
      .result       (res_data)
   );

   asfp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res_data),
      .free      (out_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_pm25_value  = out_data.pm25_value;
   assign rsp_tvoc_value  = out_data.tvoc_value;
   assign rsp_pm25_level  = out_data.pm25_level;
   assign rsp_tvoc_level  = out_data.tvoc_level;
   assign rsp_checksum_ok = out_data.checksum_ok;

endmodule

// ----- hw/rtl/asfp_checker.sv -----
`timescale 1ns / 1ps
`include "air_sensor_frame_parser_assert.svh"

module asfp_checker import asfp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pm25_value,
   input logic [7:0]  rsp_tvoc_value,
   input logic [2:0]  rsp_pm25_level,
   input logic [2:0]  rsp_tvoc_level,
   input logic        rsp_checksum_ok
);

   logic        rsp_stall;
   logic [30:0] rsp_payload;
   logic        tvoc_graded;
   logic        pm_none_match;

   // Terms shared by the checks below
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_payload   = {rsp_pm25_value, rsp_tvoc_value, rsp_pm25_level,
                           rsp_tvoc_level, rsp_checksum_ok};
   assign tvoc_graded   = rsp_valid && (rsp_tvoc_level != TVOC_LVL_NONE);
   assign pm_none_match = (rsp_pm25_level == PM_LVL_NONE) == (rsp_pm25_value[15:8] == 8'd0);

   // Output is empty right after reset
   `ASFP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   // A stalled result holds its payload
   `ASFP_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload), "stall")

   // Input is stalled only while a result is stuck
   `ASFP_ASSERT(a_backpressure, clock, reset, !req_ready |-> rsp_stall, "req_ready low")

   // TVOC level agrees with the raw value
   `ASFP_ASSERT(a_tvoc_level, clock, reset, tvoc_graded |-> rsp_tvoc_value == {5'd0, rsp_tvoc_level}, "tvoc")

   // PM2.5 level none exactly when the high byte is zero
   `ASFP_ASSERT(a_pm_level, clock, reset, rsp_valid |-> pm_none_match, "pm25 level mismatch")

endmodule

bind air_sensor_frame_parser asfp_checker u_asfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pm25_value  (rsp_pm25_value),
   .rsp_tvoc_value  (rsp_tvoc_value),
   .rsp_pm25_level  (rsp_pm25_level),
   .rsp_tvoc_level  (rsp_tvoc_level),
   .rsp_checksum_ok (rsp_checksum_ok)
);
